>>> design/bitmap_row_pixel_unpacker_macros.svh
// ---------------------------------------------------------------------------
// Bitmap row pixel unpacker: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef BITMAP_ROW_PIXEL_UNPACKER_MACROS_SVH
`define BITMAP_ROW_PIXEL_UNPACKER_MACROS_SVH

// Same-cycle implication.
`define BMPU_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmpu: assertion failed");

// Next-cycle implication.
`define BMPU_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmpu: assertion failed");

`endif

>>> design/bmpu_pkg.sv
// ---------------------------------------------------------------------------
// Bitmap row pixel unpacker: package
// Widths, register and depth codes, and the structs passed between units.
// ---------------------------------------------------------------------------
`default_nettype none

package bmpu_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int CFG_W      = 13;
    localparam int COORD_W    = 12;
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = $clog2(PAL_DEPTH);
    localparam int COLOR_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int ROW_LEN_W  = $clog2(4 * MAX_DIM + 1);
    localparam int BITS_W     = $clog2(32 * MAX_DIM + 32);
    localparam int CNT_W      = 4;
    localparam int SUB_W      = 3;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 56;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_DEPTH_MODE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Depth codes
    localparam logic [2:0] DEPTH_1BIT  = 3'd0;
    localparam logic [2:0] DEPTH_4BIT  = 3'd1;
    localparam logic [2:0] DEPTH_8BIT  = 3'd2;
    localparam logic [2:0] DEPTH_24BIT = 3'd3;
    localparam logic [2:0] DEPTH_32BIT = 3'd4;

    // Input item kinds
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    typedef enum logic [1:0] {
        KIND_BIT1,
        KIND_NIB4,
        KIND_IDX8,
        KIND_DIRECT
    } pix_kind_t;

    // One pixel-array byte's worth of pixels, waiting to be drained
    typedef struct packed {
        pix_kind_t            kind;
        logic [BYTE_W-1:0]    data;
        logic [CNT_W-1:0]     count;
        logic [COORD_W-1:0]   x_base;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   x_last;
        logic                 last_row;
        logic [COLOR_W-1:0]   rgb;
        logic [BYTE_W-1:0]    alpha;
    } job_t;

    typedef struct packed {
        logic                 we;
        logic [PAL_AW-1:0]    addr;
        logic [COLOR_W-1:0]   data;
    } pal_wr_t;

    typedef struct packed {
        logic                 re;
        logic [PAL_AW-1:0]    addr;
    } pal_rd_t;

endpackage

`default_nettype wire

>>> design/bmpu_palette_ram.sv
// ---------------------------------------------------------------------------
// Bitmap row pixel unpacker: palette memory
// 256 x 24 synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bmpu_palette_ram (
    input  wire logic                        clk,
    input  wire bmpu_pkg::pal_wr_t           wr,
    input  wire bmpu_pkg::pal_rd_t           rd,
    output logic [bmpu_pkg::COLOR_W-1:0]     rd_data
);
    import bmpu_pkg::*;

    logic [COLOR_W-1:0] mem [PAL_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    // A read in the same cycle as a write to the same entry returns the old colour.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.re)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/bmpu_front.sv
// ---------------------------------------------------------------------------
// Bitmap row pixel unpacker: input front end
// Holds the configuration and row position, writes palette entries and turns
// each pixel-array byte into a job of zero to eight pixels.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bitmap_row_pixel_unpacker_macros.svh"

module bmpu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [bmpu_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bmpu_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [0:0]                    s_tuser,
    input  wire logic                          job_free,
    output logic                               job_load,
    output bmpu_pkg::job_t                     job,
    output bmpu_pkg::pal_wr_t                  pal_wr
);
    import bmpu_pkg::*;

    logic [2:0]           depth_reg,  depth_next;
    logic [CFG_W-1:0]     width_reg,  width_next;
    logic [CFG_W-1:0]     height_reg, height_next;
    logic [ROW_LEN_W-1:0] byte_reg,   byte_next;
    logic [CFG_W-1:0]     col_reg,    col_next;
    logic [COORD_W-1:0]   rows_reg,   rows_next;
    logic [1:0]           comp_reg,   comp_next;
    logic [COLOR_W-1:0]   part_reg,   part_next;

    logic [2:0]           mode_eff;
    logic [CFG_W-1:0]     w_eff, h_eff;
    logic [BITS_W-1:0]    w_ext, row_bits;
    logic [ROW_LEN_W-1:0] row_len;
    logic                 byte_last;
    logic [CFG_W-1:0]     col_rem;
    logic                 col_open;
    logic [CNT_W-1:0]     ppb, n_pix;
    logic [1:0]           comp_last;
    logic                 direct_emit;
    logic [BYTE_W-1:0]    b;
    logic                 accept, is_pixel;
    logic [CFG_W-1:0]     rows_ext, rows_inc;
    logic [CFG_W-1:0]     y_full, w_m1;
    pix_kind_t            kind;
    logic [COLOR_W-1:0]   direct_rgb;
    logic [BYTE_W-1:0]    direct_alpha;

    // Palette writes share the input interlock with pixel bytes, so that a
    // write never overtakes the reads of an earlier byte.
    assign s_tready = job_free;
    assign accept   = s_tvalid && s_tready;
    assign is_pixel = (s_tuser[0] == REQ_PIXEL);
    assign b        = s_tdata[39:32];

    assign pal_wr.we   = accept && (s_tuser[0] == REQ_PALETTE);
    assign pal_wr.addr = s_tdata[7:0];
    assign pal_wr.data = s_tdata[31:8];

    always_comb
    begin
        mode_eff = (depth_reg > DEPTH_32BIT) ? DEPTH_32BIT : depth_reg;
        if (width_reg == '0)
            w_eff = CFG_W'(1);
        else if (width_reg > CFG_W'(MAX_DIM))
            w_eff = CFG_W'(MAX_DIM);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = CFG_W'(1);
        else if (height_reg > CFG_W'(MAX_DIM))
            h_eff = CFG_W'(MAX_DIM);
        else
            h_eff = height_reg;

        w_ext = BITS_W'(w_eff);
        unique case (mode_eff)
            DEPTH_1BIT:  begin row_bits = w_ext;                       ppb = CNT_W'(8); kind = KIND_BIT1;   end
            DEPTH_4BIT:  begin row_bits = w_ext << 2;                  ppb = CNT_W'(2); kind = KIND_NIB4;   end
            DEPTH_8BIT:  begin row_bits = w_ext << 3;                  ppb = CNT_W'(1); kind = KIND_IDX8;   end
            DEPTH_24BIT: begin row_bits = (w_ext << 4) + (w_ext << 3); ppb = CNT_W'(1); kind = KIND_DIRECT; end
            default:     begin row_bits = w_ext << 5;                  ppb = CNT_W'(1); kind = KIND_DIRECT; end
        endcase
        // Row length in bytes, rounded up to whole 32-bit words
        row_len   = ROW_LEN_W'(((row_bits + BITS_W'(31)) >> 5) << 2);
        byte_last = ({1'b0, byte_reg} + (ROW_LEN_W + 1)'(1)) >= {1'b0, row_len};

        col_open  = col_reg < w_eff;
        col_rem   = w_eff - col_reg;
        comp_last = (mode_eff == DEPTH_24BIT) ? 2'd2 : 2'd3;
        direct_emit = (kind == KIND_DIRECT) && col_open && (comp_reg >= comp_last);

        if (kind == KIND_DIRECT)
            n_pix = direct_emit ? CNT_W'(1) : '0;
        else if (col_rem < CFG_W'(ppb))
            n_pix = col_rem[CNT_W-1:0];
        else
            n_pix = ppb;

        if (mode_eff == DEPTH_24BIT)
        begin
            direct_rgb   = {b, part_reg[15:0]};
            direct_alpha = 8'hff;
        end
        else
        begin
            direct_rgb   = part_reg;
            direct_alpha = b;
        end

        rows_ext = CFG_W'(rows_reg);
        rows_inc = rows_ext + CFG_W'(1);
        y_full   = h_eff - CFG_W'(1) - rows_ext;
        w_m1     = w_eff - CFG_W'(1);
    end

    always_comb
    begin
        job_load     = accept && is_pixel && (n_pix != '0);
        job.kind     = kind;
        job.data     = b;
        job.count    = n_pix;
        job.x_base   = col_reg[COORD_W-1:0];
        job.y        = y_full[COORD_W-1:0];
        job.x_last   = w_m1[COORD_W-1:0];
        job.last_row = (rows_inc == h_eff);
        job.rgb      = direct_rgb;
        job.alpha    = (kind == KIND_DIRECT) ? direct_alpha : 8'hff;
    end

    always_comb
    begin
        depth_next  = depth_reg;
        width_next  = width_reg;
        height_next = height_reg;
        byte_next   = byte_reg;
        col_next    = col_reg;
        rows_next   = rows_reg;
        comp_next   = comp_reg;
        part_next   = part_reg;

        priority if (cfg_we)
        begin
            if (cfg_index == REG_DEPTH_MODE)
                depth_next = cfg_wdata[2:0];
            else if (cfg_index == REG_IMAGE_WIDTH)
                width_next = cfg_wdata;
            else if (cfg_index == REG_IMAGE_HEIGHT)
                height_next = cfg_wdata;
            // Any register write restarts the image; the palette is kept.
            if (cfg_index <= REG_IMAGE_HEIGHT)
            begin
                byte_next = '0;
                col_next  = '0;
                rows_next = '0;
                comp_next = '0;
                part_next = '0;
            end
        end
        else if (accept && is_pixel)
        begin
            col_next = col_reg + CFG_W'(n_pix);
            if (direct_emit)
            begin
                comp_next = '0;
                part_next = '0;
            end
            else if ((kind == KIND_DIRECT) && col_open)
            begin
                comp_next = comp_reg + 2'd1;
                unique case (comp_reg)
                    2'd0:    part_next = part_reg | {16'h0, b};
                    2'd1:    part_next = part_reg | {8'h0, b, 8'h0};
                    2'd2:    part_next = part_reg | {b, 16'h0};
                    default: part_next = part_reg;
                endcase
            end

            if (byte_last)
            begin
                byte_next = '0;
                col_next  = '0;
                comp_next = '0;
                part_next = '0;
                rows_next = (rows_inc >= h_eff) ? '0 : rows_inc[COORD_W-1:0];
            end
            else
            begin
                byte_next = byte_reg + ROW_LEN_W'(1);
            end
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= DEPTH_32BIT;
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            byte_reg   <= '0;
            col_reg    <= '0;
            rows_reg   <= '0;
            comp_reg   <= '0;
            part_reg   <= '0;
        end
        else
        begin
            depth_reg  <= depth_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            byte_reg   <= byte_next;
            col_reg    <= col_next;
            rows_reg   <= rows_next;
            comp_reg   <= comp_next;
            part_reg   <= part_next;
        end
    end

    `BMPU_ASSERT_IMP(a_col_in_row, 1'b1, col_reg <= w_eff)
    `BMPU_ASSERT_IMP(a_row_in_image, 1'b1, rows_ext < h_eff)
    `BMPU_ASSERT_IMP(a_byte_in_row, 1'b1, byte_reg < row_len)

endmodule

`default_nettype wire

>>> design/bmpu_drain.sv
// ---------------------------------------------------------------------------
// Bitmap row pixel unpacker: pixel drain
// Steps through the pending job one pixel a cycle unless the output stalls,
// issues the palette read and presents the finished pixel in the output
// register.
`default_nettype none
`include "bitmap_row_pixel_unpacker_macros.svh"

module bmpu_drain (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_load,
    input  wire bmpu_pkg::job_t                job,
    output logic                               job_free,
    output bmpu_pkg::pal_rd_t                  pal_rd,
    input  wire logic [bmpu_pkg::COLOR_W-1:0]  pal_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bmpu_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    output logic [0:0]                         m_tuser
);
    import bmpu_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] rgb;
        logic [BYTE_W-1:0]  alpha;
        logic               use_pal;
        logic               last;
        logic               eoi;
    } out_desc_t;

    logic               job_valid_reg, job_valid_next;
    job_t               job_reg;
    logic [SUB_W-1:0]   k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    out_desc_t          out_reg, out_next;

    logic               advance, issue, last_pix;
    logic [CNT_W-1:0]   k_ext;
    logic [COORD_W-1:0] x_cur;
    logic [COLOR_W-1:0] color;

    assign advance  = !out_valid_reg || m_tready;
    assign issue    = job_valid_reg && advance;
    assign k_ext    = CNT_W'(k_reg);
    assign last_pix = (k_ext == job_reg.count - CNT_W'(1));
    assign job_free = !job_valid_reg || (issue && last_pix);
    assign x_cur    = job_reg.x_base + COORD_W'(k_reg);

    // Palette address for pixel k of the current byte
    always_comb
    begin
        pal_rd.re = issue && (job_reg.kind != KIND_DIRECT);
        unique case (job_reg.kind)
            KIND_BIT1:   pal_rd.addr = PAL_AW'(job_reg.data[SUB_W'(7) - k_reg]);
            KIND_NIB4:   pal_rd.addr = k_reg[0] ? PAL_AW'(job_reg.data[3:0])
                                                : PAL_AW'(job_reg.data[7:4]);
            KIND_IDX8:   pal_rd.addr = job_reg.data;
            KIND_DIRECT: pal_rd.addr = '0;
            default:     pal_rd.addr = '0;
        endcase
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        k_next         = k_reg;
        if (job_load)
        begin
            job_valid_next = 1'b1;
            k_next         = '0;
        end
        else if (issue && last_pix)
        begin
            job_valid_next = 1'b0;
        end
        else if (issue)
        begin
            k_next = k_reg + SUB_W'(1);
        end

        out_next.x       = x_cur;
        out_next.y       = job_reg.y;
        out_next.rgb     = job_reg.rgb;
        out_next.alpha   = job_reg.alpha;
        out_next.use_pal = (job_reg.kind != KIND_DIRECT);
        out_next.last    = last_pix;
        out_next.eoi     = job_reg.last_row && (x_cur == job_reg.x_last);

        if (issue)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
        if (issue)
        begin
            out_reg <= out_next;
        end
    end

    // The palette data register only moves on an issue, so it holds while stalled.
    assign color    = out_reg.use_pal ? pal_data : out_reg.rgb;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.alpha, color[7:0], color[15:8], color[23:16],
                       out_reg.y, out_reg.x};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.eoi;

    `BMPU_ASSERT_IMP(a_k_in_job, job_valid_reg, k_ext < job_reg.count)
    `BMPU_ASSERT_NXT(a_job_holds_in_stall, job_valid_reg && !advance, job_valid_reg && $stable(k_reg))
    `BMPU_ASSERT_IMP(a_eoi_ends_byte, out_valid_reg && out_reg.eoi, out_reg.last)
    `BMPU_ASSERT_IMP(a_load_only_when_free, job_load, job_free)

endmodule

`default_nettype wire

>>> design/bitmap_row_pixel_unpacker.sv
// ---------------------------------------------------------------------------
// Bitmap row pixel unpacker
// Turns palette entries and bottom-up bitmap pixel-array bytes into RGBA
// pixels with their column and row.
// ---------------------------------------------------------------------------
//  channel | direction | contents
//  s_*     | in        | tdata: palette_index, palette_color, data_byte; tuser: req_type
//  m_*     | out       | tdata: pixel_x, pixel_y, red, green, blue, alpha;
//          |           | tlast: last_of_item; tuser: end_of_image
//  cfg_*   | in        | register writes: depth_mode, image_width, image_height
//
//  A byte's pixels pass the job register, then the output register together
//  with the palette RAM read. Unless the output stalls, the pixel drain emits one
//  pixel a cycle, so 8-, 24- and 32-bit bytes and palette writes are taken every
//  cycle, while a 1-bit byte holds the input until its up to 8 pixels are issued
//  and a 4-bit byte until its up to 2. The palette RAM is not cleared by reset;
//  entries are valid once written. A stalled output holds its pixel and the pending job.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_row_pixel_unpacker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [bmpu_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // palette_index [7:0], palette_color [31:8], data_byte [39:32]
    input  wire logic [bmpu_pkg::S_DATA_W-1:0] s_tdata,
    // req_type [0]
    input  wire logic [0:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pixel_x [11:0], pixel_y [23:12], red [31:24], green [39:32],
    // blue [47:40], alpha [55:48]
    output logic [bmpu_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    // end_of_image [0]
    output logic [0:0]                         m_tuser
);
    import bmpu_pkg::*;

    logic               job_free, job_load;
    job_t               job;
    pal_wr_t            pal_wr;
    pal_rd_t            pal_rd;
    logic [COLOR_W-1:0] pal_data;

    bmpu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_free  (job_free),
        .job_load  (job_load),
        .job       (job),
        .pal_wr    (pal_wr)
    );

    bmpu_palette_ram u_palette (
        .clk     (clk),
        .wr      (pal_wr),
        .rd      (pal_rd),
        .rd_data (pal_data)
    );

    bmpu_drain u_drain (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_load (job_load),
        .job      (job),
        .job_free (job_free),
        .pal_rd   (pal_rd),
        .pal_data (pal_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> dv/bitmap_row_pixel_unpacker_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap row pixel unpacker: testbench
// Fills the palette and feeds short directed rows in every depth mode. Then
// random images follow under changing register settings, source gaps and
// output back-pressure. A scoreboard predicts each RGBA pixel, with its
// position and flags, and compares every output transfer in order.
// ---------------------------------------------------------------------------

module bitmap_row_pixel_unpacker_test;

    import bmpu_pkg::*;

    // Register index past the end of the list, and the top depth selector
    localparam logic [1:0] REG_UNUSED      = 2'd3;
    localparam logic [2:0] DEPTH_ALIAS_MAX = 3'd7;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         STALL_CYCLES    = 300;
    localparam int         PAL_FILL        = 32;
    localparam int         FULL_ROW_BYTES  = 16;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               last_of_item;
        logic               end_of_image;
    } pixel_t;

    class pixel_tracker;
        logic [COLOR_W-1:0] palette [PAL_DEPTH];
        logic [2:0]         depth_sel;
        logic [CFG_W-1:0]   width_reg;
        logic [CFG_W-1:0]   height_reg;
        int unsigned        byte_in_row;
        int unsigned        column_next;
        int unsigned        rows_done;
        int unsigned        component_count;
        logic [COLOR_W-1:0] partial_pixel;
        pixel_t             expected_pixels [$];
        int                 mismatches;
        int                 transfers;
        int                 pixels_checked;
        int                 images_seen;
        int                 reg_writes;

        function new();
            depth_sel      = DEPTH_32BIT;
            width_reg      = 1;
            height_reg     = 1;
            mismatches     = 0;
            transfers      = 0;
            pixels_checked = 0;
            images_seen    = 0;
            reg_writes     = 0;
            restart();
        endfunction

        function void restart();
            byte_in_row     = 0;
            column_next     = 0;
            rows_done       = 0;
            component_count = 0;
            partial_pixel   = '0;
        endfunction

        // Zero reads as one and anything past the maximum saturates.
        function int unsigned dim(logic [CFG_W-1:0] value);
            if (value == 0)
                return 1;
            if (value > MAX_DIM)
                return MAX_DIM;
            return value;
        endfunction

        function logic [2:0] mode();
            return (depth_sel > DEPTH_32BIT) ? DEPTH_32BIT : depth_sel;
        endfunction

        function int unsigned row_bytes();
            int unsigned bits;
            case (mode())
                DEPTH_1BIT:  bits = 1;
                DEPTH_4BIT:  bits = 4;
                DEPTH_8BIT:  bits = 8;
                DEPTH_24BIT: bits = 24;
                default:     bits = 32;
            endcase
            return 4 * ((bits * dim(width_reg) + 31) / 32);
        endfunction

        function int unsigned image_rows();
            return dim(height_reg);
        endfunction

        function void write_reg(logic [1:0] index, logic [CFG_W-1:0] value);
            reg_writes++;
            case (index)
                REG_DEPTH_MODE:   depth_sel  = value[2:0];
                REG_IMAGE_WIDTH:  width_reg  = value;
                REG_IMAGE_HEIGHT: height_reg = value;
                default:          return;
            endcase
            restart();
        endfunction

        function void emit(logic [COLOR_W-1:0] rgb, logic [7:0] a);
            pixel_t      px;
            int unsigned w;
            int unsigned h;
            w = dim(width_reg);
            h = dim(height_reg);
            px.x            = COORD_W'(column_next);
            px.y            = COORD_W'(h - 1 - rows_done);
            px.red          = rgb[23:16];
            px.green        = rgb[15:8];
            px.blue         = rgb[7:0];
            px.alpha        = a;
            px.last_of_item = 1'b0;
            px.end_of_image = (column_next + 1 == w) && (rows_done + 1 == h);
            expected_pixels.push_back(px);
            column_next++;
        endfunction

        function void note_item(logic req, logic [7:0] index, logic [COLOR_W-1:0] colour,
                                logic [7:0] data);
            int unsigned w;
            int unsigned h;
            int unsigned first;
            logic [2:0]  m;
            pixel_t      px;
            transfers++;
            if (req == REQ_PALETTE)
            begin
                palette[index] = colour;
                return;
            end
            w = dim(width_reg);
            h = dim(height_reg);
            m = mode();
            if (rows_done >= h)
                restart();
            first = expected_pixels.size();
            case (m)
                DEPTH_1BIT:
                    for (int k = 0; k < 8; k++)
                        if (column_next < w)
                            emit(palette[data[7-k]], 8'hff);
                DEPTH_4BIT:
                    for (int k = 0; k < 2; k++)
                        if (column_next < w)
                            emit(palette[(k == 0) ? data[7:4] : data[3:0]], 8'hff);
                DEPTH_8BIT:
                    if (column_next < w)
                        emit(palette[data], 8'hff);
                default:
                    if (column_next < w)
                    begin
                        // Components gather as B, G, R; the closing byte is R or A.
                        if (component_count < ((m == DEPTH_24BIT) ? 2 : 3))
                        begin
                            partial_pixel |= COLOR_W'(data) << (8 * component_count);
                            component_count++;
                        end
                        else
                        begin
                            if (m == DEPTH_24BIT)
                                emit({data, partial_pixel[15:0]}, 8'hff);
                            else
                                emit(partial_pixel, data);
                            component_count = 0;
                            partial_pixel   = '0;
                        end
                    end
            endcase
            if (expected_pixels.size() > first)
            begin
                px = expected_pixels.pop_back();
                px.last_of_item = 1'b1;
                expected_pixels.push_back(px);
            end
            if (byte_in_row + 1 >= row_bytes())
            begin
                byte_in_row     = 0;
                column_next     = 0;
                component_count = 0;
                partial_pixel   = '0;
                rows_done++;
                if (rows_done >= h)
                    rows_done = 0;
            end
            else
                byte_in_row++;
        endfunction

        function string describe(pixel_t px);
            return $sformatf("x=%0d y=%0d r=%02h g=%02h b=%02h a=%02h last=%b end=%b",
                             px.x, px.y, px.red, px.green, px.blue, px.alpha,
                             px.last_of_item, px.end_of_image);
        endfunction

        function void check_pixel(logic [M_DATA_W-1:0] tdata, logic tlast, logic tuser);
            pixel_t got;
            pixel_t want;
            got.x            = tdata[11:0];
            got.y            = tdata[23:12];
            got.red          = tdata[31:24];
            got.green        = tdata[39:32];
            got.blue         = tdata[47:40];
            got.alpha        = tdata[55:48];
            got.last_of_item = tlast;
            got.end_of_image = tuser;
            pixels_checked++;
            if (tuser === 1'b1)
                images_seen++;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: %s", describe(got));
                return;
            end
            want = expected_pixels.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch at %0t\n  expected %s\n  got      %s",
                             $realtime, describe(want), describe(got));
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic [0:0]            m_tuser;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int sink_hold     = 0;
    int random_items  = 0;

    pixel_tracker tracker = new();

    bitmap_row_pixel_unpacker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL bitmap_row_pixel_unpacker");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            tracker.check_pixel(m_tdata, m_tlast, m_tuser[0]);

    // Receiver: random idling, or a long hold-off when one is requested.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // The directed fill writes only the bottom and top sixteen palette entries,
    // so an 8-bit index is drawn from those two ranges.
    function automatic logic [7:0] pal_byte();
        return {($urandom_range(0, 1) == 0) ? 4'h0 : 4'hf, 4'($urandom)};
    endfunction

    task automatic send_item(logic req, logic [7:0] index, logic [COLOR_W-1:0] colour,
                             logic [7:0] data);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {data, colour, index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_item(req, index, colour, data);
    endtask

    // The ignored fields carry random values to show that they are ignored.
    task automatic send_pixel_byte(logic [7:0] data);
        send_item(REQ_PIXEL, 8'($urandom), COLOR_W'($urandom), data);
    endtask

    task automatic send_palette(logic [7:0] index, logic [COLOR_W-1:0] colour);
        send_item(REQ_PALETTE, index, colour, 8'($urandom));
    endtask

    // Always waits at least one edge, so the valid is never lowered and
    // raised again in the same step.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.expected_pixels.size() != 0);
    endtask

    // A padding byte may still be in flight after the last pixel has come.
    task automatic settle();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.write_reg(index, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [2:0] depth, logic [CFG_W-1:0] width,
                             logic [CFG_W-1:0] height);
        settle();
        write_reg(REG_DEPTH_MODE, CFG_W'(depth));
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
    endtask

    task automatic directed_checks();
        logic [COLOR_W-1:0] colour;
        // Reset settings: one 32-bit pixel makes a whole image.
        send_pixel_byte(8'h00);
        send_pixel_byte(8'hff);
        send_pixel_byte(8'h5a);
        send_pixel_byte(8'ha5);
        for (int i = 0; i < PAL_FILL; i++)
        begin
            if (i == 0)
                colour = '0;
            else if (i == PAL_FILL - 1)
                colour = '1;
            else
                colour = COLOR_W'($urandom);
            send_palette((i < PAL_FILL / 2) ? 8'(i) : 8'(PAL_DEPTH - PAL_FILL + i), colour);
        end
        // 1-bit, MSB first; the second byte stops at column 12, then padding.
        configure(DEPTH_1BIT, 13, 1);
        send_pixel_byte(8'ha5);
        send_pixel_byte(8'h3c);
        send_pixel_byte(8'hff);
        send_pixel_byte(8'h00);
        // 4-bit with an odd width: the low nibble of the second byte is dropped.
        configure(DEPTH_4BIT, 3, 1);
        send_pixel_byte(8'h1e);
        send_pixel_byte(8'hf0);
        send_pixel_byte(8'hff);
        send_pixel_byte(8'h00);
        configure(DEPTH_8BIT, 2, 1);
        send_pixel_byte(8'h00);
        send_pixel_byte(8'hff);
        send_pixel_byte(8'hf1);
        send_pixel_byte(8'h0e);
        configure(DEPTH_24BIT, 1, 1);
        send_pixel_byte(8'h10);
        send_pixel_byte(8'h20);
        send_pixel_byte(8'h30);
        send_pixel_byte(8'hff);
        // Top selector, zero sizes, and a write to a missing register
        // in the middle of a pixel, which must not restart it.
        configure(DEPTH_ALIAS_MAX, 0, 0);
        send_pixel_byte(8'h01);
        send_pixel_byte(8'h02);
        settle();
        write_reg(REG_UNUSED, CFG_W'($urandom));
        send_pixel_byte(8'h03);
        send_pixel_byte(8'h04);
        // Oversized width and height saturate: the bottom row is 4095.
        configure(DEPTH_8BIT, 8191, 8191);
        send_pixel_byte(8'hff);
        send_pixel_byte(8'h00);
        send_pixel_byte(8'hf8);
    endtask

    // One register setting, then one or two whole images, sometimes with a
    // partial image left behind for the next setting to cut off.
    task automatic random_session();
        logic [2:0]  depth;
        int unsigned width;
        int unsigned height;
        int unsigned total;
        if ($urandom_range(0, 7) == 0)
            depth = 3'($urandom_range(DEPTH_32BIT + 1, DEPTH_ALIAS_MAX));
        else
            depth = 3'($urandom_range(DEPTH_1BIT, DEPTH_32BIT));
        case (depth)
            DEPTH_1BIT, DEPTH_4BIT: width = $urandom_range(1, 40);
            DEPTH_8BIT:             width = $urandom_range(1, 12);
            default:                width = $urandom_range(1, 5);
        endcase
        if ($urandom_range(0, 9) == 0)
            width = 0;
        height = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        configure(depth, CFG_W'(width), CFG_W'(height));
        total = tracker.row_bytes() * tracker.image_rows() * $urandom_range(1, 2);
        if ($urandom_range(0, 2) == 0)
            total += $urandom_range(1, tracker.row_bytes());
        for (int unsigned i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_palette(8'($urandom), COLOR_W'($urandom));
                random_items++;
            end
            if ($urandom_range(0, 49) == 0)
                pause_until_drained();
            send_pixel_byte((tracker.mode() == DEPTH_8BIT) ? pal_byte() : 8'($urandom));
            random_items++;
        end
    endtask

    // Hold the output off while 1-bit bytes keep coming, so the block fills up.
    task automatic stall_output();
        configure(DEPTH_1BIT, 64, 1);
        sink_hold = STALL_CYCLES;
        for (int i = 0; i < 24; i++)
            send_pixel_byte(8'($urandom));
        pause_until_drained();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DEPTH_MODE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_PALETTE;
        src_idle_pct  = 16;
        sink_idle_pct = 88;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();
        while (random_items < 40)
            random_session();

        src_idle_pct  = 88;
        sink_idle_pct = 16;
        stall_output();
        while (random_items < 80)
            random_session();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (random_items < 120)
            random_session();

        // The start of a full-width 1-bit row, left for the end of the run.
        configure(DEPTH_1BIT, MAX_DIM, 1);
        repeat (FULL_ROW_BYTES) send_pixel_byte(8'($urandom));
        settle();

        $display("Checked %0d pixels from %0d input transfers across %0d register writes.",
                 tracker.pixels_checked, tracker.transfers, tracker.reg_writes);
        $display("All depth modes, row padding, size clamping, stalls and %0d whole images.",
                 tracker.images_seen);
        if (tracker.expected_pixels.size() != 0)
            $display("%0d expected pixels never arrived", tracker.expected_pixels.size());
        if (tracker.mismatches == 0 && tracker.expected_pixels.size() == 0)
            $display("PASS bitmap_row_pixel_unpacker");
        else
            $display("FAIL bitmap_row_pixel_unpacker");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/bmpu_pkg.sv
design/bmpu_palette_ram.sv
design/bmpu_front.sv
design/bmpu_drain.sv
design/bitmap_row_pixel_unpacker.sv
dv/bitmap_row_pixel_unpacker_test.sv
